// File: hw/rtl/uart_bootloader_flash_host_macros.svh
// Assertion macros used by the checker file.
`ifndef UART_BOOTLOADER_FLASH_HOST_MACROS_SVH
`define UART_BOOTLOADER_FLASH_HOST_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define UBF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define UBF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/ubfh_pkg.sv
// Package with types, codes and constants of the bootloader host.
package ubfh_pkg;
  localparam int unsigned ChunkBytes = 256;
  localparam int unsigned MaxTx = 5;
  localparam int unsigned TxCntW = 3;

  localparam logic [2:0] OpStart = 3'd0;
  localparam logic [2:0] OpRx = 3'd1;
  localparam logic [2:0] OpTick = 3'd2;
  localparam logic [2:0] OpImg = 3'd3;
  localparam logic [2:0] OpCancel = 3'd4;

  localparam logic [2:0] FailNone = 3'd0;
  localparam logic [2:0] FailNack = 3'd1;
  localparam logic [2:0] FailUnexp = 3'd2;
  localparam logic [2:0] FailTimeout = 3'd3;
  localparam logic [2:0] FailBadId = 3'd4;
  localparam logic [2:0] FailCancel = 3'd5;

  localparam logic [2:0] RegBase = 3'd0;
  localparam logic [2:0] RegSize = 3'd1;
  localparam logic [2:0] RegAck = 3'd2;
  localparam logic [2:0] RegNack = 3'd3;
  localparam logic [2:0] RegShort = 3'd4;
  localparam logic [2:0] RegErase = 3'd5;
  localparam logic [2:0] RegWrite = 3'd6;

  localparam logic [4:0] PhIdle = 5'd0;
  localparam logic [4:0] PhSync = 5'd1;
  localparam logic [4:0] PhIdCmd = 5'd2;
  localparam logic [4:0] PhIdRead = 5'd3;
  localparam logic [4:0] PhIdAck = 5'd4;
  localparam logic [4:0] PhExtCmd = 5'd5;
  localparam logic [4:0] PhExtPay = 5'd6;
  localparam logic [4:0] PhGlbCmd = 5'd7;
  localparam logic [4:0] PhGlbPay = 5'd8;
  localparam logic [4:0] PhWrCmd = 5'd9;
  localparam logic [4:0] PhWrAddr = 5'd10;
  localparam logic [4:0] PhWrData = 5'd11;
  localparam logic [4:0] PhWrAck = 5'd12;
  localparam logic [4:0] PhGoCmd = 5'd13;
  localparam logic [4:0] PhGoAddr = 5'd14;
  localparam logic [4:0] PhDone = 5'd15;
  localparam logic [4:0] PhFailed = 5'd16;

  localparam logic [7:0] CmdSync = 8'h7F;
  localparam logic [7:0] CmdGetId = 8'h02;
  localparam logic [7:0] CmdExtErase = 8'h44;
  localparam logic [7:0] CmdGlbErase = 8'h43;
  localparam logic [7:0] CmdWrite = 8'h31;
  localparam logic [7:0] CmdGo = 8'h21;

  // Configuration register set.
  typedef struct packed {
    logic [31:0] base_address;
    logic [24:0] image_size;
    logic [7:0]  ack_code;
    logic [7:0]  nack_code;
    logic [15:0] short_ticks;
    logic [15:0] erase_ticks;
    logic [15:0] write_ticks;
  } cfg_t;

  // Status carried by every result item.
  typedef struct packed {
    logic        want_image_byte;
    logic        id_valid;
    logic [15:0] chip_ident;
    logic [24:0] written_count;
    logic        finished;
    logic [2:0]  fail_code;
  } status_t;

  // One finished input item: up to five bytes plus status.
  typedef struct packed {
    logic [MaxTx-1:0][7:0] bytes;
    logic [TxCntW-1:0]     count;
    status_t               status;
  } batch_t;
endpackage

// File: hw/rtl/uart_bootloader_flash_host.sv
// Top level of the UART bootloader host.
// Drives the host side of a serial bootloader exchange: sync, get ID, erase
// (extended, falling back to global), chunked write with XOR checksums, go.
// Input channel: op, rx_value and image_byte with in_valid_i/in_stall_o.
// Each input item yields one result item per transmitted byte (up to five),
// or one item with tx_valid low; last marks the final item of a group.
// Output channel: out_valid_o/out_stall_i, one field per port.
// Results are held in the result register once an item is accepted. Each cycle
// in which the receiver does not stall, the register emits one byte; an item
// is accepted in the cycle the previous group's last result is taken, so the
// block takes no new item while results of the last one are still pending.
// The serializing result register sets the pace of input acceptance.
// When the receiver stalls, the current result holds and input is stalled.
// Reset clears all protocol state to idle and restores register defaults.
// Configuration writes via cfg_we_i/cfg_index_i/cfg_data_i apply at once.
module uart_bootloader_flash_host import ubfh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  rx_value_i,
  input  logic [7:0]  image_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_value_o,
  output logic        want_image_byte_o,
  output logic        id_valid_o,
  output logic [15:0] chip_ident_o,
  output logic [24:0] written_count_o,
  output logic        finished_o,
  output logic [2:0]  fail_code_o,
  output logic        last_o
);
  cfg_t    cfg;
  batch_t  batch;
  status_t status;
  logic    busy, step;

  assign in_stall_o = busy;
  assign step = in_valid_i && !busy;

  ubfh_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );

  ubfh_core u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .step_i(step), .op_i, .rx_value_i,
    .image_byte_i, .batch_o(batch)
  );

  ubfh_out u_out (
    .clk_i, .rst_ni, .load_i(step), .batch_i(batch), .busy_o(busy),
    .out_valid_o, .out_stall_i, .tx_valid_o, .tx_value_o,
    .status_o(status), .last_o
  );

  assign want_image_byte_o = status.want_image_byte;
  assign id_valid_o = status.id_valid;
  assign chip_ident_o = status.chip_ident;
  assign written_count_o = status.written_count;
  assign finished_o = status.finished;
  assign fail_code_o = status.fail_code;
endmodule

// File: hw/rtl/ubfh_cfg.sv
// Configuration register file of the bootloader host.
module ubfh_cfg import ubfh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);
  cfg_t cfg_q;

  // Register writes by index; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_address <= 32'h0800_0000;
      cfg_q.image_size <= '0;
      cfg_q.ack_code <= 8'd121;
      cfg_q.nack_code <= 8'd31;
      cfg_q.short_ticks <= 16'd1000;
      cfg_q.erase_ticks <= 16'd30000;
      cfg_q.write_ticks <= 16'd5000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegBase:  cfg_q.base_address <= cfg_data_i;
        RegSize:  cfg_q.image_size <= cfg_data_i[24:0];
        RegAck:   cfg_q.ack_code <= cfg_data_i[7:0];
        RegNack:  cfg_q.nack_code <= cfg_data_i[7:0];
        RegShort: cfg_q.short_ticks <= cfg_data_i[15:0];
        RegErase: cfg_q.erase_ticks <= cfg_data_i[15:0];
        RegWrite: cfg_q.write_ticks <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

// File: hw/rtl/ubfh_core.sv
// Protocol state and per-item step logic of the bootloader host.
module ubfh_core import ubfh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [2:0] op_i,
  input  logic [7:0] rx_value_i,
  input  logic [7:0] image_byte_i,
  output batch_t     batch_o
);
  logic [4:0]  phase_q, phase_d;
  logic [15:0] wait_q, wait_d;
  logic [31:0] addr_q, addr_d;
  logic [24:0] done_q, done_d;
  logic [8:0]  left_q, left_d;
  logic [7:0]  xor_q, xor_d;
  logic [15:0] ident_q, ident_d;
  logic [1:0]  seen_q, seen_d;
  logic        glb_q, glb_d;
  logic [2:0]  err_q, err_d;

  logic [MaxTx-1:0][7:0] tx;
  logic [TxCntW-1:0]     txn;
  logic        active, awaiting;
  logic [24:0] rem;
  logic [8:0]  len;
  logic [7:0]  ib_xor;
  logic [31:0] ack_addr;

  // Remaining bytes clamped to one chunk.
  assign rem = (done_q < cfg_i.image_size) ? cfg_i.image_size - done_q : '0;
  assign len = (rem > 25'(ChunkBytes)) ? 9'(ChunkBytes) : rem[8:0];
  assign active = (phase_q >= PhSync) && (phase_q <= PhGoAddr);
  assign awaiting = active && (phase_q != PhIdRead) && (phase_q != PhWrData);
  assign ib_xor = xor_q ^ image_byte_i;
  assign ack_addr = (phase_q == PhGoCmd) ? cfg_i.base_address : addr_q;

  // Next state and transmit bytes for one item.
  always_comb begin
    phase_d = phase_q; wait_d = wait_q; addr_d = addr_q; done_d = done_q;
    left_d = left_q; xor_d = xor_q; ident_d = ident_q; seen_d = seen_q;
    glb_d = glb_q; err_d = err_q; tx = '0; txn = '0;
    unique case (op_i)
      OpStart: begin
        if (!active) begin
          addr_d = cfg_i.base_address; done_d = '0; left_d = '0; xor_d = '0;
          ident_d = '0; seen_d = '0; glb_d = 1'b0; err_d = FailNone;
          tx[0] = CmdSync; txn = 3'd1;
          phase_d = PhSync; wait_d = cfg_i.short_ticks;
        end
      end
      OpRx: begin
        if (phase_q == PhIdRead) begin
          unique case (seen_q)
            2'd0: begin
              if (rx_value_i == 8'd0) begin
                err_d = FailBadId; phase_d = PhFailed;
              end else begin
                seen_d = 2'd1;
              end
            end
            2'd1: begin
              ident_d = {rx_value_i, 8'd0}; seen_d = 2'd2;
            end
            default: begin
              ident_d = {ident_q[15:8], rx_value_i}; seen_d = 2'd3;
              phase_d = PhIdAck; wait_d = cfg_i.short_ticks;
            end
          endcase
        end else if (awaiting) begin
          if (rx_value_i == cfg_i.ack_code) begin
            unique case (phase_q)
              PhSync: begin
                tx[0] = CmdGetId; tx[1] = ~CmdGetId; txn = 3'd2;
                phase_d = PhIdCmd; wait_d = cfg_i.short_ticks;
              end
              PhIdCmd: begin
                phase_d = PhIdRead; seen_d = 2'd0; wait_d = cfg_i.short_ticks;
              end
              PhIdAck: begin
                tx[0] = CmdExtErase; tx[1] = ~CmdExtErase; txn = 3'd2;
                phase_d = PhExtCmd; wait_d = cfg_i.short_ticks;
              end
              PhExtCmd: begin
                tx[0] = 8'hFF; tx[1] = 8'hFF; tx[2] = 8'h00; txn = 3'd3;
                phase_d = PhExtPay; wait_d = cfg_i.erase_ticks;
              end
              PhGlbCmd: begin
                tx[0] = 8'hFF; tx[1] = 8'h00; txn = 3'd2;
                phase_d = PhGlbPay; wait_d = cfg_i.erase_ticks;
              end
              PhExtPay, PhGlbPay: begin
                wait_d = cfg_i.short_ticks; txn = 3'd2;
                if (done_q < cfg_i.image_size) begin
                  tx[0] = CmdWrite; tx[1] = ~CmdWrite; phase_d = PhWrCmd;
                end else begin
                  tx[0] = CmdGo; tx[1] = ~CmdGo; phase_d = PhGoCmd;
                end
              end
              PhWrCmd, PhGoCmd: begin
                tx[0] = ack_addr[31:24]; tx[1] = ack_addr[23:16];
                tx[2] = ack_addr[15:8]; tx[3] = ack_addr[7:0];
                tx[4] = ack_addr[31:24] ^ ack_addr[23:16] ^ ack_addr[15:8]
                        ^ ack_addr[7:0];
                txn = 3'd5; wait_d = cfg_i.short_ticks;
                phase_d = (phase_q == PhWrCmd) ? PhWrAddr : PhGoAddr;
              end
              PhWrAddr: begin
                if (len == 9'd0) begin
                  tx[0] = CmdGo; tx[1] = ~CmdGo; txn = 3'd2;
                  phase_d = PhGoCmd; wait_d = cfg_i.short_ticks;
                end else begin
                  tx[0] = 8'(len - 9'd1); txn = 3'd1;
                  xor_d = 8'(len - 9'd1); left_d = len; phase_d = PhWrData;
                end
              end
              PhWrAck: begin
                done_d = done_q + 25'(len);
                addr_d = addr_q + 32'(len);
                wait_d = cfg_i.short_ticks; txn = 3'd2;
                if (done_q + 25'(len) < cfg_i.image_size) begin
                  tx[0] = CmdWrite; tx[1] = ~CmdWrite; phase_d = PhWrCmd;
                end else begin
                  tx[0] = CmdGo; tx[1] = ~CmdGo; phase_d = PhGoCmd;
                end
              end
              PhGoAddr: phase_d = PhDone;
              default: ;
            endcase
          end else if (phase_q == PhExtCmd || phase_q == PhExtPay) begin
            // Fall back to global erase on any extended erase failure.
            glb_d = 1'b1; tx[0] = CmdGlbErase; tx[1] = ~CmdGlbErase; txn = 3'd2;
            phase_d = PhGlbCmd; wait_d = cfg_i.short_ticks;
          end else begin
            err_d = (rx_value_i == cfg_i.nack_code) ? FailNack : FailUnexp;
            phase_d = PhFailed;
          end
        end
      end
      OpTick: begin
        if (phase_q == PhIdRead || awaiting) begin
          if (wait_q <= 16'd1) begin
            wait_d = '0;
            if (phase_q == PhExtCmd || phase_q == PhExtPay) begin
              glb_d = 1'b1; tx[0] = CmdGlbErase; tx[1] = ~CmdGlbErase; txn = 3'd2;
              phase_d = PhGlbCmd; wait_d = cfg_i.short_ticks;
            end else begin
              err_d = FailTimeout; phase_d = PhFailed;
            end
          end else begin
            wait_d = wait_q - 16'd1;
          end
        end
      end
      OpImg: begin
        if (phase_q == PhWrData) begin
          tx[0] = image_byte_i; txn = 3'd1; xor_d = ib_xor;
          if (left_q <= 9'd1) begin
            left_d = '0; tx[1] = ib_xor; txn = 3'd2;
            phase_d = PhWrAck; wait_d = cfg_i.write_ticks;
          end else begin
            left_d = left_q - 9'd1;
          end
        end
      end
      OpCancel: begin
        if (active) begin
          err_d = FailCancel; phase_d = PhFailed;
        end
      end
      default: ;
    endcase
  end

  // State registers, updated once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; wait_q <= '0; addr_q <= '0; done_q <= '0; left_q <= '0;
      xor_q <= '0; ident_q <= '0; seen_q <= '0; glb_q <= 1'b0; err_q <= FailNone;
    end else if (step_i) begin
      phase_q <= phase_d; wait_q <= wait_d; addr_q <= addr_d; done_q <= done_d;
      left_q <= left_d; xor_q <= xor_d; ident_q <= ident_d; seen_q <= seen_d;
      glb_q <= glb_d; err_q <= err_d;
    end
  end

  // The batch reflects status after the step.
  always_comb begin
    batch_o.bytes = tx;
    batch_o.count = txn;
    batch_o.status.want_image_byte = (phase_d == PhWrData);
    batch_o.status.id_valid = (seen_d == 2'd3);
    batch_o.status.chip_ident = ident_d;
    batch_o.status.written_count = done_d;
    batch_o.status.finished = (phase_d == PhDone);
    batch_o.status.fail_code = err_d;
  end

  logic unused_glb;
  assign unused_glb = glb_q;
endmodule

// File: hw/rtl/ubfh_out.sv
// Result register that serializes the bytes of one item.
module ubfh_out import ubfh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  batch_t      batch_i,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_value_o,
  output status_t     status_o,
  output logic        last_o
);
  batch_t            b_q;
  logic              full_q;
  logic [TxCntW-1:0] idx_q;
  logic              take, fin;
  logic [TxCntW-1:0] rem;

  assign take = full_q && !out_stall_i;
  assign rem = (b_q.count == '0) ? '0 : b_q.count - 3'd1;
  assign fin = (idx_q == rem);
  assign busy_o = full_q && !(take && fin);

  // Hold a batch and step through its bytes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0; idx_q <= '0;
    end else if (load_i) begin
      full_q <= 1'b1; idx_q <= '0;
    end else if (take) begin
      if (fin) full_q <= 1'b0;
      else idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) b_q <= batch_i;
  end

  assign out_valid_o = full_q;
  assign tx_valid_o = (b_q.count != '0);
  assign tx_value_o = (b_q.count != '0) ? b_q.bytes[idx_q] : 8'd0;
  assign status_o = b_q.status;
  assign last_o = fin;
endmodule

// File: hw/rtl/ubfh_checker.sv
// Port-level checker for the bootloader host, bound to the top level.
`include "uart_bootloader_flash_host_macros.svh"
module ubfh_checker import ubfh_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        tx_valid_o,
  input logic [7:0]  tx_value_o,
  input logic        finished_o,
  input logic [2:0]  fail_code_o,
  input logic        last_o
);
  // An accepted item always yields a result next cycle.
  `UBF_ASSERT_NXT(a_item_result, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o,
    "accepted item produced no result")
  // Input is stalled while a group is pending and not finishing.
  `UBF_ASSERT_IMP(a_stall_busy, clk_i, rst_ni, out_valid_o && !last_o, in_stall_o,
    "input accepted during a partial group")
  // A result without a byte carries a zero value.
  `UBF_ASSERT_IMP(a_zero_tx, clk_i, rst_ni, out_valid_o && !tx_valid_o, tx_value_o == 8'd0,
    "idle result with nonzero byte")
  // Done and a failure code never show together.
  `UBF_ASSERT_IMP(a_done_ok, clk_i, rst_ni, out_valid_o && finished_o, fail_code_o == FailNone,
    "finished with a failure code")
endmodule

bind uart_bootloader_flash_host ubfh_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .tx_valid_o, .tx_value_o, .finished_o, .fail_code_o, .last_o
);
